// ----- src/script_whitespace_minifier_top_assert.svh -----
`ifndef SCRIPT_WHITESPACE_MINIFIER_TOP_ASSERT_SVH
`define SCRIPT_WHITESPACE_MINIFIER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SWM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/swm_pkg.sv -----
package swm_pkg;

    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_NONE   = 8'h00;

    // one request's worth of results: 1..3 bytes, or a bare end marker
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            bare;
        logic            done;
    } t_pkt;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == C_SPACE) || ((c >= C_TAB) && (c <= C_CR));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == C_SEMI) || (c == C_LBRACE) || (c == C_RBRACE) ||
               (c == C_LPAREN) || (c == C_RPAREN) || (c == C_LBRACK) ||
               (c == C_RBRACK) || (c == C_COMMA) || (c == C_COLON);
    endfunction

endpackage

// ----- src/swm_if.sv -----
interface swm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_last;

    modport source (output valid, output in_byte, output stream_last, input ready);
    modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

interface swm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       item_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output byte_valid,
                    output item_last, output stream_done, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input item_last, input stream_done, output ready);
endinterface

// ----- src/swm_core.sv -----
module swm_core
    import swm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    swm_in_if.sink        i_in,
    input  logic          i_room,
    output logic          o_push,
    output t_pkt          o_pkt
);

`include "script_whitespace_minifier_top_assert.svh"

    logic       r_dq, r_sq, r_esc, r_sp, r_semi;
    logic [7:0] r_lk;
    logic       n_dq, n_sq, n_esc, n_sp, n_semi;
    logic [7:0] n_lk;

    logic            acc;
    logic [7:0]      c;
    logic            last;
    logic            in_str;
    logic            held;
    logic [1:0]      n;
    logic [2:0][7:0] lst;

    assign i_in.ready = i_room;
    assign acc        = i_in.valid && i_room;
    assign c          = i_in.in_byte;
    assign last       = i_in.stream_last;

    always_comb begin
        n_dq  = r_dq;
        n_sq  = r_sq;
        n_esc = 1'b0;
        if (!r_esc) begin
            if (c == C_DQUOTE && !r_sq) begin
                n_dq = !r_dq;
            end else if (c == C_SQUOTE && !r_dq) begin
                n_sq = !r_sq;
            end else if (c == C_BSLASH) begin
                n_esc = 1'b1;
            end
        end
        in_str = n_dq || n_sq;

        lst  = '0;
        n    = 2'd0;
        held = r_semi;
        // deferred space from the previous request
        if (r_sp && !is_ws(c) && !is_punct(c)) begin
            if (held) begin
                lst[n] = C_SEMI;
                n      = n + 2'd1;
            end
            lst[n] = C_SPACE;
            n      = n + 2'd1;
            held   = 1'b0;
        end
        if (in_str || !is_ws(c)) begin
            if (held) begin
                lst[n] = C_SEMI;
                n      = n + 2'd1;
            end
            if (c == C_SEMI) begin
                held = 1'b1;
            end else begin
                held   = 1'b0;
                lst[n] = c;
                n      = n + 2'd1;
            end
        end
        n_semi = held;
        n_sp   = !in_str && is_ws(c) && (r_lk != C_NONE) && !is_ws(r_lk) && !is_punct(r_lk);
        n_lk   = (!in_str && !is_ws(c)) ? c : r_lk;
    end

    assign o_push    = acc && ((n != 2'd0) || last);
    assign o_pkt.cnt = (n == 2'd0) ? 2'd1 : n;
    assign o_pkt.bytes = lst;
    assign o_pkt.bare  = (n == 2'd0);
    assign o_pkt.done  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && last)) begin
            r_dq   <= 1'b0;
            r_sq   <= 1'b0;
            r_esc  <= 1'b0;
            r_sp   <= 1'b0;
            r_semi <= 1'b0;
            r_lk   <= C_NONE;
        end else if (acc) begin
            r_dq   <= n_dq;
            r_sq   <= n_sq;
            r_esc  <= n_esc;
            r_sp   <= n_sp;
            r_semi <= n_semi;
            r_lk   <= n_lk;
        end
    end

    `SWM_ASSERT_NEXT(a_last_clears, acc && last,
        !r_dq && !r_sq && !r_esc && !r_sp && !r_semi && (r_lk == C_NONE),
        "state not cleared after final request")
    `SWM_ASSERT(a_quotes_excl, 1'b1, !(r_dq && r_sq), "both quote modes active")
    `SWM_ASSERT(a_bare_on_last, o_push && o_pkt.bare, last, "end marker on non-final request")
    `SWM_ASSERT(a_sp_outside, r_sp, !r_dq && !r_sq, "pending space inside a string")

endmodule

// ----- src/swm_pktq.sv -----
module swm_pktq
    import swm_pkg::*;
#(
    parameter int D = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pkt     i_pkt,
    output logic     o_room,
    swm_out_if.source o_out
);

`include "script_whitespace_minifier_top_assert.svh"

    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    t_pkt          r_q [D];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_idx;

    t_pkt head;
    logic full, wr, step, fin, pop;

    assign head   = r_q[r_rp];
    assign full   = (r_cnt == CW'(D));
    assign o_room = !full;
    assign wr     = i_push && !full;

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = head.bytes[r_idx];
    assign o_out.byte_valid  = !head.bare;
    assign o_out.item_last   = fin;
    assign o_out.stream_done = fin && head.done;

    assign fin  = (r_idx == head.cnt - 2'd1);
    assign step = o_out.valid && o_out.ready;
    assign pop  = step && fin;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_idx <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + PW'(1);
            end
            if (wr && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (step) begin
                r_idx <= fin ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    `SWM_ASSERT(a_cnt_bound, 1'b1, r_cnt <= CW'(D), "queue count overflow")
    `SWM_ASSERT(a_idx_idle, r_cnt == '0, r_idx == 2'd0, "result index moved while empty")
    `SWM_ASSERT(a_idx_range, o_out.valid, r_idx < head.cnt, "result index past packet")
    `SWM_ASSERT_NEXT(a_cnt_inc, wr && !pop, r_cnt == $past(r_cnt) + CW'(1), "lost push")

endmodule

// ----- src/script_whitespace_minifier_top.sv -----
// channel  | dir | payload                                          | accept
// i_in     | in  | in_byte[7:0], stream_last                        | valid && ready
// o_out    | out | out_byte[7:0], byte_valid, item_last, stream_done | valid && ready
//
// One request is taken per cycle while the result queue has a free packet slot.
// A request yields 0..3 results, which are registered in the result queue.
// Results leave one per cycle while o_out.ready is high.
// i_rst_n is synchronous; the scan state also clears after a stream_last request.
// Output stalls back up through the Q_DEPTH-packet queue to i_in.ready.
module script_whitespace_minifier_top
    import swm_pkg::*;
#(
    parameter int Q_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swm_in_if.sink     i_in,
    swm_out_if.source  o_out
);

    logic room;
    logic push;
    t_pkt pkt;

    swm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push),
        .o_pkt   (pkt)
    );

    swm_pktq #(
        .D (Q_DEPTH)
    ) u_pktq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (pkt),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ----- bench/swm_checker.sv -----
module swm_checker
    import swm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    swm_in_if    i_in,
    swm_out_if   i_out,
    output int   o_fail_cnt,
    output int   o_pend_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       req_end;
        logic       strm_end;
    } min_char_t;

    // scanner state
    logic       in_dq;
    logic       in_sq;
    logic       esc_pend;
    logic       space_pend;
    logic       semi_held;
    logic [7:0] last_kept;

    logic [7:0] step_bytes [3];
    int         step_n;
    min_char_t  minified_q [$];
    int         fail_n = 0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == C_SPACE || (c >= C_TAB && c <= C_CR);
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        case (c)
            C_SEMI, C_LBRACE, C_RBRACE, C_LPAREN, C_RPAREN,
            C_LBRACK, C_RBRACK, C_COMMA, C_COLON: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_scan();
        in_dq      = 1'b0;
        in_sq      = 1'b0;
        esc_pend   = 1'b0;
        space_pend = 1'b0;
        semi_held  = 1'b0;
        last_kept  = C_NONE;
    endtask

    // a ';' is held back one character
    task automatic put_char(input logic [7:0] c);
        if (semi_held) begin
            step_bytes[step_n] = C_SEMI;
            step_n++;
        end
        semi_held = (c == C_SEMI);
        if (c != C_SEMI) begin
            step_bytes[step_n] = c;
            step_n++;
        end
    endtask

    task automatic minify_request(input logic [7:0] c, input logic last);
        min_char_t rec;
        step_n = 0;
        if (space_pend) begin
            space_pend = 1'b0;
            if (!is_blank(c) && !is_sep(c)) begin
                put_char(C_SPACE);
            end
        end
        if (!esc_pend) begin
            if (c == C_DQUOTE && !in_sq) begin
                in_dq = !in_dq;
            end else if (c == C_SQUOTE && !in_dq) begin
                in_sq = !in_sq;
            end else if (c == C_BSLASH) begin
                esc_pend = 1'b1;
            end
        end else begin
            esc_pend = 1'b0;
        end
        if (in_dq || in_sq) begin
            put_char(c);
        end else if (is_blank(c)) begin
            if (last_kept != C_NONE && !is_blank(last_kept) && !is_sep(last_kept)) begin
                space_pend = 1'b1;
            end
        end else begin
            put_char(c);
            last_kept = c;
        end
        if (step_n == 0 && last) begin
            rec.ch       = C_NONE;
            rec.has_ch   = 1'b0;
            rec.req_end  = 1'b1;
            rec.strm_end = 1'b1;
            minified_q.insert(minified_q.size(), rec);
        end
        for (int k = 0; k < step_n; k++) begin
            rec.ch       = step_bytes[k];
            rec.has_ch   = 1'b1;
            rec.req_end  = (k == step_n - 1);
            rec.strm_end = (k == step_n - 1) && last;
            minified_q.insert(minified_q.size(), rec);
        end
        if (last) begin
            clear_scan();
        end
    endtask

    task automatic note_fail(input string what, input min_char_t want, input min_char_t got);
        if (fail_n < 10) begin
            $display("%s: expected byte %02h valid %0b item_last %0b done %0b",
                     what, want.ch, want.has_ch, want.req_end, want.strm_end);
            $display("    got byte %02h valid %0b item_last %0b done %0b",
                     got.ch, got.has_ch, got.req_end, got.strm_end);
        end
        fail_n++;
    endtask

    // results first: a result never comes from the request taken at the same edge
    always @(posedge i_clk) begin
        min_char_t got;
        min_char_t want;
        if (!i_rst_n) begin
            clear_scan();
            minified_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.ch       = i_out.out_byte;
                got.has_ch   = i_out.byte_valid;
                got.req_end  = i_out.item_last;
                got.strm_end = i_out.stream_done;
                if (minified_q.size() == 0) begin
                    want = '0;
                    note_fail("Unexpected result", want, got);
                end else begin
                    want = minified_q.pop_front();
                    if (got !== want) begin
                        note_fail("Mismatch", want, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                minify_request(i_in.in_byte, i_in.stream_last);
            end
        end
        o_fail_cnt <= fail_n;
        o_pend_cnt <= minified_q.size();
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swm_pkg::*;

    localparam int IDLE_PCT       = 31;
    localparam int RAND_ITEMS     = 380;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    int         fail_cnt;
    int         pend_cnt;
    int         idle_cycles = 0;
    int         sent = 0;
    bit         calm = 1'b0;
    logic [7:0] text_q [$];

    script_whitespace_minifier_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    swm_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_fail_cnt (fail_cnt),
        .o_pend_cnt (pend_cnt)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 5) == 0) begin
            return C_SPACE;
        end
        return C_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 8))
            0: return C_SEMI;
            1: return C_LBRACE;
            2: return C_RBRACE;
            3: return C_LPAREN;
            4: return C_RPAREN;
            5: return C_LBRACK;
            6: return C_RBRACK;
            7: return C_COMMA;
            default: return C_COLON;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(128, 255));
            1: return 8'("0") + 8'($urandom_range(0, 9));
            2: return C_NONE;
            default: return 8'("a") + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) begin
            add_byte(s[i]);
        end
    endtask

    task automatic send_req(input logic [7:0] c, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= c;
        in_ch.stream_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    task automatic send_stream();
        foreach (text_q[i]) begin
            send_req(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // mostly token sequences; some streams are raw noise
    task automatic build_stream();
        logic [7:0] quote;
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: repeat ($urandom_range(1, 4)) add_byte(word_char());
                    3: add_byte(sep_char());
                    4, 5: repeat ($urandom_range(1, 3)) add_byte(blank_char());
                    6: begin
                        quote = $urandom_range(0, 1) ? C_DQUOTE : C_SQUOTE;
                        add_byte(quote);
                        repeat ($urandom_range(0, 5)) begin
                            case ($urandom_range(0, 5))
                                0: add_byte(blank_char());
                                1: add_byte(C_SEMI);
                                2: begin
                                    add_byte(C_BSLASH);
                                    add_byte(8'($urandom_range(0, 255)));
                                end
                                3: add_byte(quote ^ C_DQUOTE ^ C_SQUOTE);
                                4: add_byte(sep_char());
                                default: add_byte(word_char());
                            endcase
                        end
                        if ($urandom_range(0, 9) != 0) begin
                            add_byte(quote);
                        end
                    end
                    7: begin
                        add_byte(C_BSLASH);
                        add_byte(8'($urandom_range(0, 255)));
                    end
                    8: add_byte(C_SEMI);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= C_NONE;
        in_ch.stream_last <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank runs around words and separators, trailing ';' with nothing left
        add_text("a\t\nb( c ;");
        send_stream();
        // unterminated string ending in ';'
        add_text("\"k ;");
        send_stream();
        // escaped quote outside strings, quoted text, high byte, trailing blank
        add_text("\\\"b'c'");
        add_byte(8'h80);
        add_byte(C_SPACE);
        send_stream();
        // kept zero byte is not a word before a blank
        add_byte(C_NONE);
        add_byte(C_SPACE);
        add_text("z");
        add_byte(8'hFF);
        send_stream();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            calm = (sent >= 150 && sent < 240);
            build_stream();
            send_stream();
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pend_cnt != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && pend_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
